FILE: rtl/lphm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types, constants and helpers of the linear probing hash map unit.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // Table and key geometry
  localparam int TABLE_DEPTH = 128;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int VALUE_W     = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 7;
  localparam int CFG_W       = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Home slot reduction: byte sum, then a restoring remainder a few bits a cycle
  localparam int SUM_W         = $clog2(KEY_BYTES * 255 + 1);
  localparam int STEPS_PER_CYC = 4;
  localparam int DIV_CYC       = (SUM_W + STEPS_PER_CYC - 1) / STEPS_PER_CYC;
  localparam int DIV_STEPS     = DIV_CYC * STEPS_PER_CYC;
  localparam int DIV_W         = DIV_STEPS + CNT_W;
  localparam int DIVC_W        = $clog2(DIV_CYC + 1);

  // Queues between the parts
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int RSP_DEPTH   = 2;
  localparam int RPTR_W      = $clog2(RSP_DEPTH);
  localparam int RCNT_W      = $clog2(RSP_DEPTH + 1);

  // Configuration port
  localparam int              PADDR_W        = 3;
  localparam int              PDATA_W        = 32;
  localparam logic            REG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(100);

  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
      KEY_W'((65'(1) << (8 * KEY_BYTES)) - 65'(1));

  localparam logic signed [VALUE_W-1:0] FOUND_NONE = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_DELETED   = 3'd5
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] found_value;
    logic [SLOT_W-1:0]         slot_index;
  } rsp_t;

  // Request with its home slot, as handed from front to back
  typedef struct packed {
    req_t             req;
    logic [IDX_W-1:0] home;
  } work_t;

  // Clamp the programmed size to the range the table supports
  function automatic logic [CNT_W-1:0] size_in_use(logic [CFG_W-1:0] ts);
    logic [CNT_W-1:0] n;
    if (ts == '0) begin
      n = CNT_W'(1);
    end else if (32'(ts) > 32'(TABLE_DEPTH)) begin
      n = CNT_W'(TABLE_DEPTH);
    end else begin
      n = CNT_W'(ts);
    end
    return n;
  endfunction

endpackage

FILE: rtl/lphm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lphm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_front
// Accepts requests, sums the key bytes and reduces the sum modulo the size in
// use to the home slot, then hands the request on to the work queue.
// ----------------------------------------------------------------------------
module lphm_front import lphm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] n_i,
  input  logic             push_i,
  input  req_t             req_i,
  output logic             full_o,
  output logic             wq_push_o,
  output work_t            wq_data_o,
  input  logic             wq_full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_SEND
  } fstate_e;

  fstate_e           state_q;
  logic [DIVC_W-1:0] cnt_q;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [SUM_W-1:0]  sum;
  req_t              req_q;

  // Sum the key bytes as unsigned
  always_comb begin
    sum = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      sum = sum + SUM_W'(req_i.key[8*b +: 8]);
    end
  end

  // Restoring remainder steps for this cycle
  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    for (int s = 0; s < STEPS_PER_CYC; s++) begin
      if (rem_d >= div_d) begin
        rem_d = rem_d - div_d;
      end
      div_d = div_d >> 1;
    end
  end

  // Sequence accept, reduce and hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            state_q <= F_DIV;
            cnt_q   <= '0;
          end
        end
        F_DIV: begin
          cnt_q <= cnt_q + DIVC_W'(1);
          if (cnt_q == DIVC_W'(DIV_CYC - 1)) begin
            state_q <= F_SEND;
          end
        end
        F_SEND: begin
          if (!wq_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Hold the request and the remainder datapath
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      req_q <= '{operation: req_i.operation, key: req_i.key & KEY_MASK,
                 value: req_i.value};
      rem_q <= DIV_W'(sum);
      div_q <= DIV_W'(n_i) << (DIV_STEPS - 1);
    end else if (state_q == F_DIV) begin
      rem_q <= rem_d;
      div_q <= div_d;
    end
  end

  assign full_o         = (state_q != F_IDLE);
  assign wq_push_o      = (state_q == F_SEND) && !wq_full_i;
  assign wq_data_o.req  = req_q;
  assign wq_data_o.home = rem_q[IDX_W-1:0];

endmodule

FILE: rtl/lphm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_queue
// Short work queue that decouples the hashing front from the probing back.
// ----------------------------------------------------------------------------
module lphm_queue import lphm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  output logic  valid_o,
  output work_t data_o,
  input  logic  pop_i
);

  work_t              buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/lphm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_back
// Probe engine: walks slots from the home slot, checks used marks and stored
// keys, carries out the request and queues its result.
// ----------------------------------------------------------------------------
module lphm_back import lphm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] n_i,
  input  logic             wq_valid_i,
  input  work_t            wq_data_i,
  output logic             wq_pop_o,
  output rsp_t             rsp_o,
  output logic             empty_o,
  input  logic             pop_i
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP
  } bstate_e;

  bstate_e                   state_q, state_d;
  logic [IDX_W-1:0]          idx_q, idx_d, start_q, nidx;
  logic [OP_W-1:0]           op_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [TABLE_DEPTH-1:0]    used_q;
  logic [KEY_W-1:0]          key_rd;
  logic [VALUE_W-1:0]        val_rd;
  logic                      key_we, val_we, set_used, clr_used, fin, valid_op;
  rsp_t                      rsp_new;

  rsp_t              rq_q [RSP_DEPTH];
  logic [RPTR_W-1:0] rwr_q, rrd_q;
  logic [RCNT_W-1:0] rcnt_q;
  logic              rsp_pop;

  // Slot stores
  lphm_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (idx_q),
    .wdata_i (key_q),
    .raddr_i (idx_q),
    .rdata_o (key_rd)
  );

  lphm_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (idx_q),
    .wdata_i (value_q),
    .raddr_i (idx_q),
    .rdata_o (val_rd)
  );

  // Next slot with wraparound at the size in use
  assign nidx = ((CNT_W'(idx_q) + CNT_W'(1)) == n_i) ? '0 : idx_q + IDX_W'(1);

  assign valid_op = (wq_data_i.req.operation == OP_INSERT) ||
                    (wq_data_i.req.operation == OP_SEARCH) ||
                    (wq_data_i.req.operation == OP_REMOVE);

  // Decide the probe step
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    wq_pop_o = 1'b0;
    fin      = 1'b0;
    key_we   = 1'b0;
    val_we   = 1'b0;
    set_used = 1'b0;
    clr_used = 1'b0;
    rsp_new.status      = ST_NOT_FOUND;
    rsp_new.found_value = FOUND_NONE;
    rsp_new.slot_index  = '0;
    case (state_q)
      B_IDLE: begin
        if (wq_valid_i && rcnt_q != RCNT_W'(RSP_DEPTH)) begin
          wq_pop_o = 1'b1;
          if (!valid_op) begin
            fin = 1'b1;
          end else begin
            state_d = B_READ;
            idx_d   = wq_data_i.home;
          end
        end
      end
      B_READ: begin
        if (!used_q[idx_q]) begin
          fin     = 1'b1;
          state_d = B_IDLE;
          if (op_q == OP_INSERT) begin
            key_we   = 1'b1;
            val_we   = 1'b1;
            set_used = 1'b1;
            rsp_new.status     = ST_INSERTED;
            rsp_new.slot_index = SLOT_W'(idx_q);
          end
        end else begin
          state_d = B_CMP;
        end
      end
      B_CMP: begin
        state_d = B_IDLE;
        if (key_rd == key_q) begin
          fin = 1'b1;
          rsp_new.slot_index = SLOT_W'(idx_q);
          case (op_q)
            OP_INSERT: begin
              val_we = 1'b1;
              rsp_new.status = ST_UPDATED;
            end
            OP_SEARCH: begin
              rsp_new.status      = ST_FOUND;
              rsp_new.found_value = val_rd;
            end
            default: begin
              clr_used = 1'b1;
              rsp_new.status = ST_DELETED;
            end
          endcase
        end else if (nidx == start_q) begin
          // every slot in use visited once
          fin = 1'b1;
          if (op_q == OP_INSERT) begin
            rsp_new.status = ST_FULL;
          end
        end else begin
          idx_d   = nidx;
          state_d = B_READ;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Hold state and used marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      if (set_used) begin
        used_q[idx_q] <= 1'b1;
      end else if (clr_used) begin
        used_q[idx_q] <= 1'b0;
      end
    end
  end

  // Latch the request being probed
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (wq_pop_o) begin
      op_q    <= wq_data_i.req.operation;
      key_q   <= wq_data_i.req.key;
      value_q <= wq_data_i.req.value;
      start_q <= wq_data_i.home;
    end
  end

  // Result queue towards the output side
  assign empty_o = (rcnt_q == '0);
  assign rsp_o   = rq_q[rrd_q];
  assign rsp_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= '0;
      rrd_q  <= '0;
      rcnt_q <= '0;
    end else begin
      if (fin) begin
        rwr_q <= (rwr_q == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rwr_q + RPTR_W'(1);
      end
      if (rsp_pop) begin
        rrd_q <= (rrd_q == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rrd_q + RPTR_W'(1);
      end
      if (fin && !rsp_pop) begin
        rcnt_q <= rcnt_q + RCNT_W'(1);
      end else if (rsp_pop && !fin) begin
        rcnt_q <= rcnt_q - RCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      rq_q[rwr_q] <= rsp_new;
    end
  end

  // A finished request always finds room in the result queue
  a_rsp_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> rcnt_q != RCNT_W'(RSP_DEPTH))
    else $error("result queue overflow");

  // An insert into a free slot leaves that slot marked used
  a_insert_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_used |=> used_q[$past(idx_q)])
    else $error("inserted slot not marked used");

  // Only a found result carries a stored value
  a_found_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && rsp_new.status != ST_FOUND) |-> rsp_new.found_value == FOUND_NONE)
    else $error("value reported without a hit");

endmodule

FILE: rtl/linear_probe_hash_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_unit
// Key-value map with open addressing and linear probing, one result per
// request, configured through an APB-style register port.
// ----------------------------------------------------------------------------
// The front takes a request, reduces the key byte sum modulo the size in
// use with a restoring remainder and then hands it on; it takes no new
// request until that hand-off, which waits while the work queue is full.
// The back takes a request while the result queue has room, then for each
// used slot it visits checks the used mark with key and value RAM read, then
// compares the key; a free slot ends a probe after its used mark check, as
// does a key match or a visit to all slots in use. An unknown operation is
// answered as it is taken. Front and back overlap through a two-entry queue.
// Used marks are flops cleared by reset, so the map is usable straight after
// reset. Register 0 at byte address 0 holds table_size (reset 100, zero
// taken as 1, clamped to 128).
// ----------------------------------------------------------------------------
module linear_probe_hash_map_unit import lphm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               push,
  output logic               full,
  input  req_t               req_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output rsp_t               rsp_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CFG_W-1:0] table_size_q;
  logic [CNT_W-1:0] n_size;
  logic             reg_hit;
  logic             wq_push, wq_full, wq_valid, wq_pop;
  work_t            wq_in, wq_out;

  // Register decode and write
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_TABLE_SIZE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(table_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      table_size_q <= pwdata[CFG_W-1:0];
    end
  end

  assign n_size = size_in_use(table_size_q);

  lphm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .n_i       (n_size),
    .push_i    (push),
    .req_i     (req_i),
    .full_o    (full),
    .wq_push_o (wq_push),
    .wq_data_o (wq_in),
    .wq_full_i (wq_full)
  );

  lphm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .data_i  (wq_in),
    .full_o  (wq_full),
    .valid_o (wq_valid),
    .data_o  (wq_out),
    .pop_i   (wq_pop)
  );

  lphm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_size),
    .wq_valid_i (wq_valid),
    .wq_data_i  (wq_out),
    .wq_pop_o   (wq_pop),
    .rsp_o      (rsp_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule
